// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: rtl/scgr_pkg.sv
// Types and constants of the serial command genlock register block
package scgr_pkg;
	typedef enum logic [1:0] {
		PS_IDLE = 2'd0,
		PS_LETTER = 2'd1,
		PS_NUMBER = 2'd2,
		PS_TERM = 2'd3
	} parse_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_GS, OP_GM, OP_GI, OP_GJ, OP_GV, OP_GY, OP_GA, OP_GU,
		OP_GF, OP_GG, OP_GD, OP_GE, OP_GZ
	} op_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_HALF = 2'd1,
		KIND_WORD = 2'd2
	} kind_t;

	// Classified command passed from front to back
	typedef struct packed {
		op_t op;
		logic query;
		logic [31:0] number;
		logic [31:0] h_measure;
		logic [7:0] status_in;
	} cmd_t;

	localparam logic [7:0] EXEC_BYTE = 8'h80;
	localparam logic [31:0] ZERO_INC_G = 32'd390;
	localparam logic [31:0] ZERO_INC_M = 32'd483;
	localparam logic [15:0] PHASE_DEFAULT = 16'h708a;
	localparam logic [31:0] ZERO_DEFAULT = 32'h0002fec2;
	localparam logic [3:0] MODE_RESET = 4'd8;
	localparam logic [3:0] MODE_MAX = 4'd11;
	localparam logic [7:0] OVEN_MASK = 8'hbf;
	localparam logic [0:0] ADDR_SYS_G = 1'b0;
	localparam logic [0:0] ADDR_OVEN = 1'b1;

	function automatic logic [7:0] mode_bits_f(input logic [3:0] m);
		logic [7:0] r;
		case (m)
			4'd0: r = 8'h21;
			4'd1: r = 8'h0f;
			4'd2: r = 8'h0d;
			4'd3: r = 8'h05;
			4'd4: r = 8'h05;
			4'd5: r = 8'h04;
			4'd6: r = 8'h11;
			4'd7: r = 8'h01;
			4'd8: r = 8'h41;
			4'd9: r = 8'h10;
			4'd10: r = 8'h40;
			default: r = 8'h00;
		endcase
		return r;
	endfunction
endpackage

// File: rtl/scgr_front.sv
// Byte parser: accepts items, builds commands and classifies them
`include "assert_macros.svh"
module scgr_front import scgr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] rx_byte,
	input logic [31:0] h_measure,
	input logic [7:0] status_in,
	output cmd_t cmd
);
	parse_state_t state_q, state_d;
	logic [7:0] first_q, second_q;
	logic [31:0] num_q;
	logic query_q;
	logic is_letter, is_digit, is_term;
	logic [7:0] up;
	logic [31:0] num_x10;

	assign is_letter = (rx_byte inside {[8'h41:8'h5a], [8'h61:8'h7a]});
	assign is_digit = (rx_byte inside {[8'h30:8'h39]});
	assign is_term = (rx_byte inside {8'h0a, 8'h0d, 8'h3b, 8'h3f, 8'h21, 8'h24});
	assign up = (rx_byte inside {[8'h61:8'h7a]}) ? rx_byte - 8'd32 : rx_byte;
	assign num_x10 = {num_q[28:0], 3'b000} + {num_q[30:0], 1'b0};

	always_comb begin
		state_d = state_q;
		case (state_q)
			PS_IDLE: if (is_letter) state_d = PS_LETTER;
			PS_LETTER: state_d = is_letter ? PS_NUMBER : PS_IDLE;
			PS_NUMBER: begin
				if (is_term) state_d = PS_TERM;
				else if (!is_digit) state_d = PS_IDLE;
			end
			default: state_d = PS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_IDLE;
			first_q <= '0;
			second_q <= '0;
			num_q <= '0;
			query_q <= 1'b0;
		end else if (in_valid) begin
			state_q <= state_d;
			if (state_q == PS_IDLE && is_letter) first_q <= up;
			if (state_q == PS_LETTER && is_letter) begin
				second_q <= up;
				num_q <= '0;
			end
			if (state_q == PS_NUMBER) begin
				if (is_digit) num_q <= num_x10 + {28'd0, rx_byte[3:0]};
				else if (is_term) query_q <= (rx_byte == 8'h3f);
			end
		end
	end

	always_comb begin
		cmd.op = OP_NONE;
		cmd.query = query_q;
		cmd.number = num_q;
		cmd.h_measure = h_measure;
		cmd.status_in = status_in;
		if (state_q == PS_TERM && rx_byte == EXEC_BYTE && first_q == "G") begin
			case (second_q)
				"S": cmd.op = OP_GS;
				"M": cmd.op = OP_GM;
				"I": cmd.op = OP_GI;
				"J": cmd.op = OP_GJ;
				"V": cmd.op = OP_GV;
				"Y": cmd.op = OP_GY;
				"A": cmd.op = OP_GA;
				"U": cmd.op = OP_GU;
				"F": cmd.op = OP_GF;
				"G": cmd.op = OP_GG;
				"D": cmd.op = OP_GD;
				"E": cmd.op = OP_GE;
				"Z": cmd.op = OP_GZ;
				default: cmd.op = OP_NONE;
			endcase
		end
	end

	`ASSERT_NXT(a_term_to_idle, clk, arst_n, in_valid && state_q == PS_TERM, state_q == PS_IDLE)
	`ASSERT_NXT(a_letter_advance, clk, arst_n,
		in_valid && state_q == PS_IDLE && is_letter, state_q == PS_LETTER)
	`ASSERT_IMP(a_op_only_term, clk, arst_n, cmd.op != OP_NONE, state_q == PS_TERM)
endmodule

// File: rtl/scgr_back.sv
// Command executor holding the genlock registers
`include "assert_macros.svh"
module scgr_back import scgr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cmd_t cmd,
	input logic sys_g,
	input logic oven,
	output logic res_valid,
	output logic [1:0] res_kind,
	output logic [31:0] res_value,
	output logic [3:0] res_mode,
	output logic [7:0] res_bits,
	output logic res_gen_en,
	output logic res_burst_en
);
	logic [3:0] mode_q;
	logic [7:0] bits_q;
	logic [1:0] en_q;
	logic [15:0] phase_q [4];
	logic [31:0] zero_q [2];
	logic [3:0] mode_n;
	logic [7:0] bits_n;
	logic [1:0] en_n;
	logic rv;
	logic [1:0] rk;
	logic [31:0] rval;
	logic [1:0] ph;

	always_comb begin
		case (cmd.op)
			OP_GF: ph = 2'd0;
			OP_GG: ph = 2'd1;
			OP_GD: ph = 2'd2;
			default: ph = 2'd3;
		endcase
	end

	always_comb begin
		mode_n = mode_q;
		bits_n = bits_q;
		en_n = en_q;
		if (cmd.op == OP_GM && cmd.number <= {28'd0, MODE_MAX}) begin
			mode_n = cmd.number[3:0];
			bits_n = mode_bits_f(cmd.number[3:0]);
			en_n = {!(mode_n == 4'd7 || mode_n == 4'd11), mode_n != 4'd0};
		end
		rv = 1'b0;
		rk = KIND_BYTE;
		rval = '0;
		case (cmd.op)
			OP_GS: begin
				rv = 1'b1;
				rval = {24'd0, (cmd.status_in & OVEN_MASK) | {1'b0, oven, 6'd0}};
			end
			OP_GA, OP_GU: if (cmd.query) begin
				rv = 1'b1;
				rk = KIND_WORD;
				rval = zero_q[cmd.op == OP_GU];
			end
			OP_GF, OP_GG, OP_GD, OP_GE: if (cmd.query) begin
				rv = 1'b1;
				rk = KIND_HALF;
				rval = {16'd0, phase_q[ph]};
			end
			default: rv = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			bits_q <= mode_bits_f(MODE_RESET);
			en_q <= 2'b11;
			phase_q[0] <= PHASE_DEFAULT;
			phase_q[1] <= PHASE_DEFAULT;
			phase_q[2] <= '0;
			phase_q[3] <= '0;
			zero_q[0] <= ZERO_DEFAULT;
			zero_q[1] <= ZERO_DEFAULT;
			res_valid <= 1'b0;
			res_kind <= '0;
			res_value <= '0;
			res_mode <= MODE_RESET;
			res_bits <= mode_bits_f(MODE_RESET);
			res_gen_en <= 1'b1;
			res_burst_en <= 1'b1;
		end else if (cmd_valid) begin
			mode_q <= mode_n;
			bits_q <= bits_n;
			en_q <= en_n;
			res_valid <= rv;
			res_kind <= rk;
			res_value <= rval;
			res_mode <= mode_n;
			res_bits <= bits_n;
			res_gen_en <= en_n[0];
			res_burst_en <= en_n[1];
			case (cmd.op)
				OP_GI: zero_q[0] <= zero_q[0] + ZERO_INC_G;
				OP_GJ: zero_q[1] <= zero_q[1] + ZERO_INC_M;
				OP_GV: zero_q[0] <= cmd.number;
				OP_GY: zero_q[1] <= cmd.number;
				OP_GA: if (!cmd.query && sys_g)
					zero_q[0] <= cmd.h_measure - {16'd0, phase_q[0]};
				OP_GU: if (!cmd.query && !sys_g)
					zero_q[1] <= cmd.h_measure - {16'd0, phase_q[1]};
				OP_GF, OP_GG, OP_GD, OP_GE: if (!cmd.query)
					phase_q[ph] <= cmd.number[15:0];
				OP_GZ: begin
					phase_q[0] <= PHASE_DEFAULT;
					phase_q[1] <= PHASE_DEFAULT;
					zero_q[0] <= ZERO_DEFAULT;
					zero_q[1] <= ZERO_DEFAULT;
				end
				default: ;
			endcase
		end
	end

	`ASSERT_IMP(a_mode_range, clk, arst_n, 1'b1, mode_q <= MODE_MAX)
	`ASSERT_IMP(a_gen_en, clk, arst_n, 1'b1, en_q[0] == (mode_q != 4'd0))
	`ASSERT_IMP(a_kind_idle, clk, arst_n, !res_valid, res_kind == KIND_BYTE && res_value == '0)
endmodule

// File: rtl/scgr_queue.sv
// Four-entry result queue between the executor and the output
module scgr_queue import scgr_pkg::*; #(
	parameter int W = 56
) (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input logic [W-1:0] wdata,
	input logic rd,
	output logic [W-1:0] rdata,
	output logic empty,
	output logic full
);
	logic [W-1:0] mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign empty = (cnt_q == 3'd0);
	assign full = (cnt_q == 3'd4);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end
endmodule

// File: rtl/serial_command_genlock_registers_unit.sv
// Top level of the serial command genlock register block
// Usage:
//  Input channel: drive rx_byte, h_measure and status_in with push; an item is
//  taken at an edge with push high and full low. Every item yields exactly one
//  result item on the output queue (resp_* plus the current mode outputs).
//  Output channel: while empty is low the oldest result is on the ports; pop
//  takes it. Front parser classifies the byte in the cycle it is taken, the
//  executor registers the result at that edge, and a four-entry queue holds it.
//  Queue write: the result is written to the queue at the edge after the accepting
//  edge, and empty drops at that edge.
//  Throughput: one item per cycle; the executor stage is the only register
//  between input and queue, and full rises when three items are held in the
//  stage and the queue together, which a popping receiver never reaches.
//  Stall: when pop stays low, results collect in the queue and full goes high,
//  back-pressuring push without losing any item.
//  Reset (arst_n low): parser idle, mode 8, mode bits 0x41, both enables on,
//  gen phases and H zeros at their defaults, system_g_select 1,
//  oven_present 0, queue empty.
//  Config: APB writes at paddr 0 (system_g_select) and 4 (oven_present).
`include "assert_macros.svh"
module serial_command_genlock_registers_unit import scgr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] rx_byte,
	input logic [31:0] h_measure,
	input logic [7:0] status_in,
	input logic pop,
	output logic empty,
	output logic resp_valid,
	output logic [1:0] resp_kind,
	output logic [31:0] resp_value,
	output logic [3:0] lock_mode,
	output logic [7:0] mode_bits,
	output logic genlock_enable,
	output logic burst_lock_enable,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int QW = 49;
	cmd_t cmd;
	logic accept, stage_v_q, q_full, q_empty, q_rd;
	logic sys_g_q, oven_q;
	logic r_valid, r_gen, r_burst;
	logic [1:0] r_kind;
	logic [31:0] r_value;
	logic [3:0] r_mode;
	logic [7:0] r_bits;
	logic [QW-1:0] q_out;
	logic [1:0] q_cnt_q;

	assign pready = 1'b1;
	// Track occupancy of queue plus executor stage to hold off push early
	assign full = (q_cnt_q == 2'd3);
	assign accept = push && !full;
	assign q_rd = pop && !q_empty;
	assign empty = q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_g_q <= 1'b1;
			oven_q <= 1'b0;
			stage_v_q <= 1'b0;
			q_cnt_q <= '0;
		end else begin
			stage_v_q <= accept;
			q_cnt_q <= q_cnt_q + {1'b0, accept} - {1'b0, q_rd};
			if (psel && penable && pwrite) begin
				if (paddr[2] == ADDR_SYS_G && paddr[1:0] == 2'd0) sys_g_q <= pwdata[0];
				if (paddr[2] == ADDR_OVEN && paddr[1:0] == 2'd0) oven_q <= pwdata[0];
			end
		end
	end

	assign prdata = (paddr[2] == ADDR_OVEN) ? {31'd0, oven_q} : {31'd0, sys_g_q};

	scgr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .rx_byte(rx_byte),
		.h_measure(h_measure), .status_in(status_in), .cmd(cmd)
	);

	scgr_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(accept), .cmd(cmd),
		.sys_g(sys_g_q), .oven(oven_q),
		.res_valid(r_valid), .res_kind(r_kind), .res_value(r_value),
		.res_mode(r_mode), .res_bits(r_bits), .res_gen_en(r_gen),
		.res_burst_en(r_burst)
	);

	scgr_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr(stage_v_q),
		.wdata({r_valid, r_kind, r_value, r_mode, r_bits, r_gen, r_burst}),
		.rd(q_rd), .rdata(q_out), .empty(q_empty), .full(q_full)
	);

	assign {resp_valid, resp_kind, resp_value, lock_mode, mode_bits,
		genlock_enable, burst_lock_enable} = q_out;

	`ASSERT_IMP(a_no_overflow, clk, arst_n, q_full, !stage_v_q || q_rd)
	`ASSERT_NXT(a_push_lands, clk, arst_n, stage_v_q, !q_empty)
endmodule

// File: tb/tb_serial_command_genlock_registers_unit.sv
// Testbench for the serial command genlock register block: parser, commands and config
`timescale 1ns / 100ps

module tb_serial_command_genlock_registers_unit import scgr_pkg::*;;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [2:0] REG_SYS_G = 3'd0;
	localparam logic [2:0] REG_OVEN = 3'd4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] rx_byte = '0;
	logic [31:0] h_measure = '0;
	logic [7:0] status_in = '0;
	logic pop = 1'b0;
	logic empty;
	logic resp_valid;
	logic [1:0] resp_kind;
	logic [31:0] resp_value;
	logic [3:0] lock_mode;
	logic [7:0] mode_bits;
	logic genlock_enable;
	logic burst_lock_enable;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	serial_command_genlock_registers_unit uut (.*);

	always #10 clk = ~clk;

	// One reply plus the mode outputs after each byte
	typedef struct packed {
		logic valid;
		logic [1:0] kind;
		logic [31:0] value;
		logic [3:0] mode;
		logic [7:0] bits;
		logic gen_en;
		logic burst_en;
	} reply_t;

	// Directed row: byte, h, status, and an optional typed-in expectation
	typedef struct {
		logic [7:0] ch;
		logic [31:0] h;
		logic [7:0] st;
		bit fixed;
		reply_t want;
	} row_t;

	reply_t replies_due[$];
	int errors = 0;
	int cycles = 0;
	bit stall_free = 1'b0;

	// Predictor copy of the block's state
	parse_state_t ps;
	logic [7:0] let1, let2;
	logic [31:0] num;
	logic qry;
	logic [3:0] mode_q;
	logic [7:0] bits_q;
	logic [1:0] en_q;
	logic [15:0] phase_q [4];
	logic [31:0] zero_q [2];
	logic sys_g, oven;

	function automatic logic [7:0] mode_code(input logic [3:0] m);
		logic [7:0] tbl [12];
		tbl = '{8'h21, 8'h0f, 8'h0d, 8'h05, 8'h05, 8'h04,
			8'h11, 8'h01, 8'h41, 8'h10, 8'h40, 8'h00};
		return tbl[m];
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	task automatic restore_defaults();
		phase_q[0] = PHASE_DEFAULT;
		phase_q[1] = PHASE_DEFAULT;
		zero_q[0] = ZERO_DEFAULT;
		zero_q[1] = ZERO_DEFAULT;
	endtask

	task automatic reset_model();
		ps = PS_IDLE; let1 = '0; let2 = '0; num = '0; qry = 1'b0;
		mode_q = MODE_RESET; bits_q = 8'h41; en_q = 2'b11;
		phase_q[2] = '0; phase_q[3] = '0;
		sys_g = 1'b1; oven = 1'b0;
		restore_defaults();
	endtask

	// Run a parsed command; fills the reply when there is one
	task automatic run_command(input logic [31:0] h, input logic [7:0] st,
		inout reply_t r);
		int ph;
		int sy;
		ph = -1;
		if (let1 != "G") return;
		case (let2)
			"S": begin
				r.valid = 1; r.kind = KIND_BYTE;
				r.value = {24'd0, (st & OVEN_MASK) | {1'b0, oven, 6'd0}};
			end
			"M": begin
				if (num <= 32'(MODE_MAX)) begin
					mode_q = num[3:0];
					bits_q = mode_code(num[3:0]);
					en_q = {~(mode_q == 4'd7 || mode_q == 4'd11), mode_q != 0};
				end
			end
			"I": zero_q[0] += ZERO_INC_G;
			"J": zero_q[1] += ZERO_INC_M;
			"V": zero_q[0] = num;
			"Y": zero_q[1] = num;
			"A", "U": begin
				sy = (let2 == "A") ? 0 : 1;
				if (qry) begin
					r.valid = 1; r.kind = KIND_WORD; r.value = zero_q[sy];
				end else if ((sy == 0) == sys_g) begin
					zero_q[sy] = h - 32'(phase_q[sy]);
				end
			end
			"F": ph = 0;
			"G": ph = 1;
			"D": ph = 2;
			"E": ph = 3;
			"Z": restore_defaults();
			default: ;
		endcase
		if (ph >= 0) begin
			if (qry) begin
				r.valid = 1; r.kind = KIND_HALF; r.value = {16'd0, phase_q[ph]};
			end else begin
				phase_q[ph] = num[15:0];
			end
		end
	endtask

	// Advance the parser by one byte and return the predicted result
	task automatic predict_reply(input logic [7:0] c, input logic [31:0] h,
		input logic [7:0] st, output reply_t r);
		r = '0;
		case (ps)
			PS_IDLE: if (is_alpha(c)) begin
				let1 = to_upper(c); ps = PS_LETTER;
			end
			PS_LETTER: if (is_alpha(c)) begin
				let2 = to_upper(c); ps = PS_NUMBER; num = '0;
			end else begin
				ps = PS_IDLE;
			end
			PS_NUMBER: if (c >= "0" && c <= "9") begin
				num = num * 10 + 32'(c - "0");
			end else if (c == 8'd10 || c == 8'd13 || c == ";" || c == "?" ||
				c == "!" || c == "$") begin
				ps = PS_TERM; qry = (c == "?");
			end else begin
				ps = PS_IDLE;
			end
			default: begin
				ps = PS_IDLE;
				if (c == EXEC_BYTE) run_command(h, st, r);
			end
		endcase
		r.mode = mode_q; r.bits = bits_q;
		r.gen_en = en_q[0]; r.burst_en = en_q[1];
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Send one item; hold it until taken, then queue its prediction.
	// Leave push high so the next item can follow with no gap.
	task automatic send_byte(input logic [7:0] c, input logic [31:0] h,
		input logic [7:0] st, input bit fixed, input reply_t want);
		reply_t r;
		bit was_full;
		rx_byte <= c; h_measure <= h; status_in <= st; push <= 1'b1;
		forever begin
			was_full = full;
			@(posedge clk);
			if (!was_full) break;
			@(negedge clk);
		end
		predict_reply(c, h, st, r);
		if (fixed && r != want) report_mismatch("typed row", 32'(r), 32'(want));
		replies_due.push_back(r);
		@(negedge clk);
	endtask

	// Drop push and leave the input idle
	task automatic idle_cycle();
		push <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (replies_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write a register with setup and access cycles, while idle
	task automatic apb_write(input logic [2:0] addr, input logic v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= {31'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == REG_SYS_G) sys_g = v; else oven = v;
	endtask

	task automatic send_text(input string s, input logic [31:0] h, input logic [7:0] st);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], h, st, 1'b0, '0);
	endtask

	// Random command letter, drawn uniformly from the thirteen letters the executor decodes
	function automatic logic [7:0] random_char();
		logic [7:0] alpha [] = '{"S", "M", "I", "J", "V", "Y", "A", "U", "F", "G", "D", "E", "Z"};
		return alpha[$urandom_range(0, 12)];
	endfunction

	task automatic send_random_command();
		logic [7:0] terms [6] = '{8'd10, 8'd13, ";", "?", "!", "$"};
		logic [31:0] h;
		logic [7:0] st;
		logic [7:0] c;
		int digits;
		h = $urandom(); st = 8'($urandom_range(0, 255));
		c = ($urandom_range(0, 9) == 0) ? random_char() : "G";
		if ($urandom_range(0, 1)) c = c | 8'h20;
		send_byte(c, h, st, 1'b0, '0);
		c = random_char();
		if ($urandom_range(0, 1)) c = c | 8'h20;
		send_byte(c, h, st, 1'b0, '0);
		digits = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
		for (int i = 0; i < digits; i++)
			send_byte(8'("0" + $urandom_range(0, 9)), h, st, 1'b0, '0);
		if ($urandom_range(0, 15) == 0) begin
			send_byte(8'($urandom_range(0, 255)), h, st, 1'b0, '0);
		end else begin
			send_byte(terms[$urandom_range(0, 5)], h, st, 1'b0, '0);
			send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : EXEC_BYTE,
				h, st, 1'b0, '0);
		end
	endtask

	// Receiver: compare each popped result with the oldest prediction
	always @(posedge clk) begin
		reply_t got, want;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb_serial_command_genlock_registers_unit: FAIL");
				$finish;
			end
			if (pop && !empty) begin
				got = {resp_valid, resp_kind, resp_value, lock_mode, mode_bits,
					genlock_enable, burst_lock_enable};
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected result", got.value, '0);
				end else begin
					want = replies_due.pop_front();
					if (got.valid !== want.valid)
						report_mismatch("resp_valid", 32'(got.valid), 32'(want.valid));
					if (got.kind !== want.kind)
						report_mismatch("resp_kind", 32'(got.kind), 32'(want.kind));
					if (got.value !== want.value)
						report_mismatch("resp_value", got.value, want.value);
					if (got.mode !== want.mode)
						report_mismatch("lock_mode", 32'(got.mode), 32'(want.mode));
					if (got.bits !== want.bits)
						report_mismatch("mode_bits", 32'(got.bits), 32'(want.bits));
					if (got.gen_en !== want.gen_en)
						report_mismatch("genlock_enable", 32'(got.gen_en), 32'(want.gen_en));
					if (got.burst_en !== want.burst_en)
						report_mismatch("burst_lock_enable", 32'(got.burst_en),
							32'(want.burst_en));
				end
			end
		end
	end

	// Stall pattern: runs of pops and holds, with stall-free stretches
	always @(negedge clk) begin
		if (stall_free) pop <= 1'b1;
		else pop <= (($urandom_range(0, 3) != 0) || (cycles % 37 < 9));
	end

	initial begin
		row_t rows [$];
		reply_t idle_reply;
		int burst;
		reset_model();
		idle_reply = '{valid: 0, kind: 0, value: 0, mode: MODE_RESET, bits: 8'h41,
			gen_en: 1, burst_en: 1};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: status query with all-ones status and with status 0x40
		rows.push_back('{"G", 0, 0, 1, idle_reply});
		rows.push_back('{"s", 0, 0, 1, idle_reply});
		rows.push_back('{"?", 0, 0, 1, idle_reply});
		rows.push_back('{EXEC_BYTE, '1, 8'hff, 1,
			'{1, KIND_BYTE, 32'hbf, MODE_RESET, 8'h41, 1, 1}});
		foreach (rows[i]) send_byte(rows[i].ch, rows[i].h, rows[i].st, rows[i].fixed, rows[i].want);
		send_text("GS$", 0, 0); send_byte(EXEC_BYTE, 0, 8'h40, 0, '0);
		// Every mode, out-of-range mode, wrapping number
		for (int m = 0; m <= 12; m++) begin
			send_text($sformatf("GM%0d;", m), 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		end
		send_text("gm99999999999!", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		// Queries, adds, sets, auto-zero with wrap, defaults, bad bytes
		send_text("GA?", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		send_text("GI\n", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		send_text("GJ\r", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		send_text("GV4294967295;", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		send_text("GI;", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		send_text("GA;", 0, 0); send_byte(EXEC_BYTE, 32'd5, 0, 0, '0);
		send_text("GU;", 0, 0); send_byte(EXEC_BYTE, '1, 0, 0, '0);
		send_text("GF123456;", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		send_text("GF?", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		send_text("GZ;", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		send_text("GE?", 0, 0); send_byte(8'h7f, 0, 0, 0, '0);
		send_text("1G#XQ;", 0, 0); send_byte(EXEC_BYTE, 0, 0, 0, '0);
		wait_drained();

		// Random phases through every config setting
		for (int phase = 0; phase < 4; phase++) begin
			apb_write(REG_SYS_G, phase[0]);
			apb_write(REG_OVEN, phase[1]);
			stall_free = (phase == 2);
			for (int k = 0; k < 10; k++) begin
				burst = $urandom_range(1, 4);
				for (int b = 0; b < burst; b++) begin
					if ($urandom_range(0, 9) == 0)
						send_byte(8'($urandom_range(0, 255)), $urandom(),
							8'($urandom_range(0, 255)), 0, '0);
					else
						send_random_command();
				end
				repeat ($urandom_range(0, 3)) idle_cycle();
			end
			// Hold the sender until every result has come
			wait_drained();
		end

		stall_free = 1'b1;
		wait_drained();
		repeat (10) @(negedge clk);
		if (errors == 0 && replies_due.size() == 0) begin
			$display("tb_serial_command_genlock_registers_unit: PASS");
		end else begin
			$display("tb_serial_command_genlock_registers_unit: FAIL");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl
rtl/scgr_pkg.sv
rtl/scgr_front.sv
rtl/scgr_back.sv
rtl/scgr_queue.sv
rtl/serial_command_genlock_registers_unit.sv
tb/tb_serial_command_genlock_registers_unit.sv
